@@ src/efr_pkg.sv @@
`timescale 1ns / 1ps

package efr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 10;
    localparam int unsigned CRC_W  = 16;

    localparam logic [BYTE_W-1:0] ESC_BYTE     = 8'h00;
    localparam logic [BYTE_W-1:0] ESC_LITERAL  = 8'hFF;
    localparam logic [BYTE_W-1:0] ESC_END      = 8'hFD;
    localparam logic [BYTE_W-1:0] ESC_FRAMEERR = 8'hFE;
    localparam logic [BYTE_W-1:0] ESC_ABORT    = 8'hFA;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;
    localparam logic [CRC_W-1:0] CRC_GOOD = 16'hF0B8;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 10'd605;

    typedef enum logic [2:0] {
        KIND_DATA     = 3'd0,
        KIND_GOOD     = 3'd1,
        KIND_BADCRC   = 3'd2,
        KIND_FRAMEERR = 3'd3,
        KIND_ABORT    = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  length;
        logic              overflowed;
        logic              last;
    } t_result;

    // reflected crc-16, one byte, lsb first
    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] b
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ src/escaped_frame_receiver.sv @@
`timescale 1ns / 1ps

// Byte-stuffed frame receiver with a reflected CRC-16 (poly 0x8408, init 0xFFFF,
// good residue 0xF0B8). Takes one link byte per cycle while o_stall is low and
// gives at most one result per byte: a data byte, or an end-of-frame beat (good,
// check failed, framing error, abort) carrying the frame length and the overflow
// flag. A byte passes an input register, then escape decode and the byte-wide CRC
// update done combinationally, then an output register with a skid stage, so the
// block sustains one byte per cycle while the output side keeps up. Bytes beyond
// max_frame_length still enter the CRC but are dropped. The length register is
// written through the cfg port, which is always ready; write it only while idle.
module escaped_frame_receiver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [efr_pkg::LEN_W-1:0]  i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [efr_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [2:0]                 o_result_kind,
    output logic [efr_pkg::BYTE_W-1:0] o_data_byte,
    output logic [efr_pkg::LEN_W-1:0]  o_frame_length,
    output logic                       o_overflowed,
    output logic                       o_frame_last
);
    import efr_pkg::*;

    logic [LEN_W-1:0]  r_max_len;
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_esc;
    logic [CRC_W-1:0]  r_crc;
    logic [LEN_W-1:0]  r_cnt;
    logic              r_ovf;

    logic              n_esc;
    logic [CRC_W-1:0]  n_crc;
    logic [LEN_W-1:0]  n_cnt;
    logic              n_ovf;

    logic              w_push_ready;
    logic              w_adv;
    logic              w_accept;
    logic              w_push;
    t_result           w_res;
    t_result           w_out;

    assign o_cfg_ready = 1'b1;
    assign w_adv       = r_in_vld && w_push_ready;
    assign o_stall     = r_in_vld && !w_push_ready;
    assign w_accept    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_comb begin
        logic              do_data;
        logic              do_end;
        logic [BYTE_W-1:0] dbyte;
        t_kind             end_kind;

        do_data  = 1'b0;
        do_end   = 1'b0;
        dbyte    = r_in_byte;
        end_kind = KIND_ABORT;
        n_esc    = r_esc;
        n_crc    = r_crc;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        w_push   = 1'b0;
        w_res    = '0;

        if (w_adv) begin
            if (r_esc) begin
                n_esc = 1'b0;
                case (r_in_byte)
                    ESC_LITERAL: begin
                        do_data = 1'b1;
                        dbyte   = ESC_BYTE;
                    end
                    ESC_END: begin
                        do_end   = 1'b1;
                        end_kind = (r_crc == CRC_GOOD) ? KIND_GOOD : KIND_BADCRC;
                    end
                    ESC_FRAMEERR: begin
                        do_end   = 1'b1;
                        end_kind = KIND_FRAMEERR;
                    end
                    ESC_ABORT: begin
                        do_end   = 1'b1;
                        end_kind = KIND_ABORT;
                    end
                    default: begin
                        // unknown escape only clears the escape
                    end
                endcase
            end else if (r_in_byte == ESC_BYTE) begin
                n_esc = 1'b1;
            end else begin
                do_data = 1'b1;
            end

            if (do_data) begin
                n_crc = crc_byte(r_crc, dbyte);
                if (r_cnt < r_max_len) begin
                    n_cnt            = r_cnt + 1'b1;
                    w_push           = 1'b1;
                    w_res.kind       = KIND_DATA;
                    w_res.data       = dbyte;
                    w_res.length     = n_cnt;
                    w_res.overflowed = r_ovf;
                    w_res.last       = 1'b0;
                end else begin
                    n_ovf = 1'b1;
                end
            end

            if (do_end) begin
                w_push           = 1'b1;
                w_res.kind       = end_kind;
                w_res.data       = '0;
                w_res.length     = r_cnt;
                w_res.overflowed = r_ovf;
                w_res.last       = 1'b1;
                n_crc            = CRC_INIT;
                n_cnt            = '0;
                n_ovf            = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
            r_crc <= CRC_INIT;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_esc <= n_esc;
            r_crc <= n_crc;
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

    efr_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_res),
        .o_push_ready(w_push_ready),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (w_out)
    );

    assign o_result_kind  = w_out.kind;
    assign o_data_byte    = w_out.data;
    assign o_frame_length = w_out.length;
    assign o_overflowed   = w_out.overflowed;
    assign o_frame_last   = w_out.last;

endmodule

@@ src/efr_out_buf.sv @@
`timescale 1ns / 1ps

module efr_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  efr_pkg::t_result i_push_data,
    output logic             o_push_ready,
    output logic             o_valid,
    input  logic             i_stall,
    output efr_pkg::t_result o_data
);
    import efr_pkg::*;

    logic    r_main_vld;
    logic    r_skid_vld;
    t_result r_main;
    t_result r_skid;
    logic    w_load_main;

    // main register may be refilled when empty or when its beat leaves
    assign w_load_main  = !r_main_vld || !i_stall;
    assign o_push_ready = !r_skid_vld;
    assign o_valid      = r_main_vld;
    assign o_data       = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_load_main) begin
            if (r_skid_vld) begin
                r_main_vld <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_main_vld <= i_push;
            end
        end else if (i_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_main) begin
            r_main <= r_skid_vld ? r_skid : i_push_data;
        end else if (i_push) begin
            r_skid <= i_push_data;
        end
    end

endmodule

@@ test/efr_checker.sv @@
`timescale 1ns / 1ps

package efr_frame_pkg;

    import efr_pkg::*;

    // bit-serial form of the reflected link crc, lsb of the byte first
    function automatic logic [CRC_W-1:0] fcs16_next(
        input logic [CRC_W-1:0]  fcs_in,
        input logic [BYTE_W-1:0] b
    );
        logic [CRC_W-1:0] c;
        logic             fb;
        c = fcs_in;
        for (int i = 0; i < BYTE_W; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

module efr_checker
    import efr_pkg::*;
    import efr_frame_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [LEN_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [2:0]        i_result_kind,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [LEN_W-1:0]  i_frame_length,
    input  logic              i_overflowed,
    input  logic              i_frame_last,
    output int                o_fail_count,
    output int                o_pending
);

    logic [LEN_W-1:0] max_len;
    logic             esc_open;
    logic [CRC_W-1:0] fcs;
    logic [LEN_W-1:0] kept;
    logic             dropped;
    t_result          expected_beats[$];
    int               fails = 0;

    task automatic absorb_payload(input logic [BYTE_W-1:0] b);
        t_result beat;
        // dropped bytes still run through the crc
        fcs = fcs16_next(fcs, b);
        if (kept < max_len) begin
            kept            = kept + 1'b1;
            beat.kind       = KIND_DATA;
            beat.data       = b;
            beat.length     = kept;
            beat.overflowed = dropped;
            beat.last       = 1'b0;
            expected_beats.push_back(beat);
        end else begin
            dropped = 1'b1;
        end
    endtask

    task automatic close_frame(input t_kind k);
        t_result beat;
        beat.kind       = k;
        beat.data       = '0;
        beat.length     = kept;
        beat.overflowed = dropped;
        beat.last       = 1'b1;
        expected_beats.push_back(beat);
        fcs     = CRC_INIT;
        kept    = '0;
        dropped = 1'b0;
    endtask

    task automatic decode_link_byte(input logic [BYTE_W-1:0] b);
        if (esc_open) begin
            esc_open = 1'b0;
            case (b)
                ESC_LITERAL:  absorb_payload(ESC_BYTE);
                ESC_END:      close_frame((fcs == CRC_GOOD) ? KIND_GOOD : KIND_BADCRC);
                ESC_FRAMEERR: close_frame(KIND_FRAMEERR);
                ESC_ABORT:    close_frame(KIND_ABORT);
                default:      ; // unknown escape only clears the escape
            endcase
        end else if (b == ESC_BYTE) begin
            esc_open = 1'b1;
        end else begin
            absorb_payload(b);
        end
    endtask

    task automatic compare_beat();
        t_result want;
        if (expected_beats.size() == 0) begin
            $error("unexpected result beat: kind %0d data %0h length %0d",
                   i_result_kind, i_data_byte, i_frame_length);
            fails++;
        end else begin
            want = expected_beats.pop_front();
            if (i_result_kind !== want.kind) begin
                $error("result_kind: expected %0d, got %0d", want.kind, i_result_kind);
                fails++;
            end
            if (i_data_byte !== want.data) begin
                $error("data_byte: expected %0h, got %0h", want.data, i_data_byte);
                fails++;
            end
            if (i_frame_length !== want.length) begin
                $error("frame_length: expected %0d, got %0d", want.length, i_frame_length);
                fails++;
            end
            if (i_overflowed !== want.overflowed) begin
                $error("overflowed: expected %0b, got %0b", want.overflowed, i_overflowed);
                fails++;
            end
            if (i_frame_last !== want.last) begin
                $error("frame_last: expected %0b, got %0b", want.last, i_frame_last);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_len  = MAX_LEN_RESET;
            esc_open = 1'b0;
            fcs      = CRC_INIT;
            kept     = '0;
            dropped  = 1'b0;
            expected_beats.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                max_len = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                decode_link_byte(i_rx_byte);
            end
            if (i_out_valid && !i_out_stall) begin
                compare_beat();
            end
        end
        o_pending    <= expected_beats.size();
        o_fail_count <= fails;
    end

endmodule

@@ test/escaped_frame_receiver_tb.sv @@
`timescale 1ns / 1ps

module escaped_frame_receiver_tb;

    import efr_pkg::*;
    import efr_frame_pkg::*;

    typedef logic [BYTE_W-1:0] t_byteq[$];

    typedef enum {
        FRAME_GOOD,
        FRAME_BADCRC,
        FRAME_ERROR,
        FRAME_ABORT
    } t_frame_end;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic [LEN_W-1:0]  i_cfg_data  = '0;
    logic              i_valid     = 1'b0;
    logic [BYTE_W-1:0] i_rx_byte   = '0;
    logic              i_stall     = 1'b0;
    logic              o_cfg_ready;
    logic              o_stall;
    logic              o_valid;
    logic [2:0]        o_result_kind;
    logic [BYTE_W-1:0] o_data_byte;
    logic [LEN_W-1:0]  o_frame_length;
    logic              o_overflowed;
    logic              o_frame_last;

    int fail_count;
    int pending_beats;
    int bytes_sent = 0;
    int gap_pct    = 0;
    int stall_pct  = 0;

    escaped_frame_receiver dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_data_byte    (o_data_byte),
        .o_frame_length (o_frame_length),
        .o_overflowed   (o_overflowed),
        .o_frame_last   (o_frame_last)
    );

    efr_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_result_kind  (o_result_kind),
        .i_data_byte    (o_data_byte),
        .i_frame_length (o_frame_length),
        .i_overflowed   (o_overflowed),
        .i_frame_last   (o_frame_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending_beats)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_raw(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    task automatic send_payload(input logic [BYTE_W-1:0] b);
        if (b == ESC_BYTE) begin
            send_raw(ESC_BYTE);
            send_raw(ESC_LITERAL);
        end else begin
            send_raw(b);
        end
    endtask

    task automatic send_frame(input t_byteq body, input t_frame_end ending);
        logic [CRC_W-1:0] fcs;
        fcs = CRC_INIT;
        foreach (body[i]) begin
            fcs = fcs16_next(fcs, body[i]);
            send_payload(body[i]);
        end
        if (ending == FRAME_GOOD || ending == FRAME_BADCRC) begin
            fcs = ~fcs;
            if (ending == FRAME_BADCRC) begin
                fcs[$urandom_range(0, CRC_W-1)] ^= 1'b1;
            end
            send_payload(fcs[7:0]);
            send_payload(fcs[15:8]);
        end
        send_raw(ESC_BYTE);
        case (ending)
            FRAME_GOOD, FRAME_BADCRC: send_raw(ESC_END);
            FRAME_ERROR:              send_raw(ESC_FRAMEERR);
            default:                  send_raw(ESC_ABORT);
        endcase
    endtask

    // bias toward the escape and control codes so they show up as payload
    function automatic logic [BYTE_W-1:0] random_payload_byte();
        case ($urandom_range(0, 15))
            0:       return ESC_BYTE;
            1:       return ESC_LITERAL;
            2:       return ESC_END;
            3:       return ESC_FRAMEERR;
            4:       return ESC_ABORT;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_byteq random_body(input int len);
        t_byteq body;
        for (int i = 0; i < len; i++) begin
            body.push_back(random_payload_byte());
        end
        return body;
    endfunction

    function automatic int random_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(0, 8);
        end
        return $urandom_range(9, 40);
    endfunction

    task automatic send_noise();
        logic [BYTE_W-1:0] b;
        if ($urandom_range(0, 1)) begin
            b = BYTE_W'($urandom_range(0, 255));
            if (b == ESC_LITERAL || b == ESC_END || b == ESC_FRAMEERR || b == ESC_ABORT) begin
                b = ESC_BYTE;
            end
            send_raw(ESC_BYTE);
            send_raw(b);
        end else begin
            repeat ($urandom_range(1, 4)) send_raw(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_traffic(input int n);
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                send_frame(random_body(random_len()), FRAME_GOOD);
            end else if (pick < 78) begin
                send_frame(random_body(random_len()), FRAME_BADCRC);
            end else if (pick < 85) begin
                send_frame(random_body(random_len()), FRAME_ERROR);
            end else if (pick < 92) begin
                send_frame(random_body(random_len()), FRAME_ABORT);
            end else begin
                send_noise();
            end
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_beats != 0);
        // bytes that give no result may still be in flight
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_max_len(input logic [LEN_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_byteq body;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap_pct   = 32;
        stall_pct = 48;

        // payload full of control codes, raw 0xff and an escaped zero
        body = '{8'h01, 8'hFF, 8'h80, 8'h7F, 8'h00, 8'hFD, 8'hFE, 8'hFA};
        send_frame(body, FRAME_GOOD);
        body = '{8'h55};
        send_frame(body, FRAME_BADCRC);
        body.delete();
        send_frame(body, FRAME_ERROR);
        send_frame(body, FRAME_ABORT);
        // double escape and an unknown escape code
        send_raw(ESC_BYTE);
        send_raw(ESC_BYTE);
        send_raw(ESC_BYTE);
        send_raw(8'h12);

        run_traffic(100);

        write_max_len(10'd1);
        run_traffic(100);

        // max length of zero: every payload byte is dropped
        write_max_len(10'd0);
        run_traffic(30);

        gap_pct   = 48;
        stall_pct = 32;
        write_max_len(10'd1023);
        // one frame long enough to fill the length counter and overflow
        send_frame(random_body(1030), FRAME_GOOD);
        run_traffic(60);

        write_max_len(LEN_W'($urandom_range(2, 40)));
        run_traffic(100);

        gap_pct   = 0;
        stall_pct = 0;
        write_max_len(10'd8);
        run_traffic(100);

        drain();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending_beats == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/efr_pkg.sv
src/efr_out_buf.sv
src/escaped_frame_receiver.sv
test/efr_checker.sv
test/escaped_frame_receiver_tb.sv
